FILE: design/spd_pkg.sv
// ---------------------------------------------------------------------------
// Serial packet deframer package
// Shared types, codes and constants of the deframer block.
// ---------------------------------------------------------------------------
package spd_pkg;

  // Item codes on the input channel.
  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_TICK = 2'd1,
    MODE_POP  = 2'd2
  } mode_t;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_NOPAY   = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START   = 2'd0,
    CFG_EOF1    = 2'd1,
    CFG_EOF2    = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_t;

  // Pop sequencer states.
  typedef enum logic [2:0] {
    P_IDLE,
    P_SUM,
    P_RD,
    P_LD,
    P_OUT
  } pop_state_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte_one;
    logic [7:0] end_byte_two;
    logic [7:0] timeout_limit;
  } cfg_t;

  // One receive-side event handed to the frame receiver.
  typedef struct packed {
    logic       byte_stb;
    logic       tick_stb;
    logic [7:0] data;
  } rx_cmd_t;

  // Configuration reset values.
  localparam logic [7:0] START_RST   = 8'd170;
  localparam logic [7:0] EOF1_RST    = 8'd13;
  localparam logic [7:0] EOF2_RST    = 8'd10;
  localparam logic [7:0] TIMEOUT_RST = 8'd20;

  // Frame layout: start, command, length, payload, checksum low/high, end pair.
  localparam logic [7:0] CMD_POS   = 8'd1;
  localparam logic [7:0] LEN_POS   = 8'd2;
  localparam logic [7:0] PAY_POS   = 8'd3;
  localparam logic [7:0] HDR_BYTES = 8'd6;
  localparam logic [7:0] TICK_MAX  = 8'hFF;

endpackage

FILE: design/serial_packet_deframer_unit.sv
// ---------------------------------------------------------------------------
// Serial packet deframer
// Frames received bytes into a ring of packet rows and pops stored packets.
// ---------------------------------------------------------------------------
// A received byte or a timeout tick is accepted while no pop is running. A
// pop first sums the checksum over the packet row, one row byte per cycle
// through the single read port of the row memory and one 16-bit adder, then
// reads, loads and presents each payload word, holding it while the consumer
// holds out_ready low; a pop of an empty queue or of a packet without payload
// gives one word. The block takes no new word until every word of a pop has
// been taken.
module serial_packet_deframer_unit #(
  parameter int SLOTS     = 8,
  parameter int ROW_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration port.
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // Input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_rx_byte,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_command,
  output logic [4:0] out_payload_length,
  output logic [7:0] out_payload_byte,
  output logic [4:0] out_byte_index,
  output logic       out_last,
  output logic       out_checksum_ok
);

  localparam int AW    = $clog2(SLOTS) + $clog2(ROW_BYTES);
  localparam int DEPTH = SLOTS << $clog2(ROW_BYTES);

  spd_pkg::cfg_t    cfg_r;
  spd_pkg::rx_cmd_t rx_cmd;
  logic             in_accept;
  logic             pop_start;
  logic             pop_busy;
  logic             retire;
  logic             q_empty;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= spd_pkg::START_RST;
      cfg_r.end_byte_one  <= spd_pkg::EOF1_RST;
      cfg_r.end_byte_two  <= spd_pkg::EOF2_RST;
      cfg_r.timeout_limit <= spd_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (spd_pkg::cfg_idx_t'(cfg_index))
        spd_pkg::CFG_START:   cfg_r.start_byte    <= cfg_wdata;
        spd_pkg::CFG_EOF1:    cfg_r.end_byte_one  <= cfg_wdata;
        spd_pkg::CFG_EOF2:    cfg_r.end_byte_two  <= cfg_wdata;
        spd_pkg::CFG_TIMEOUT: cfg_r.timeout_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Word decode: bytes and ticks go to the receiver, pops to the sequencer.
  assign in_ready         = !pop_busy;
  assign in_accept        = in_valid && in_ready;
  assign rx_cmd.byte_stb  = in_accept && (in_mode == spd_pkg::MODE_BYTE);
  assign rx_cmd.tick_stb  = in_accept && (in_mode == spd_pkg::MODE_TICK);
  assign rx_cmd.data      = in_rx_byte;
  assign pop_start        = in_accept && (in_mode == spd_pkg::MODE_POP);

  spd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  spd_rx #(
    .SLOTS     (SLOTS),
    .ROW_BYTES (ROW_BYTES)
  ) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cmd     (rx_cmd),
    .retire  (retire),
    .q_empty (q_empty),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  spd_pop #(
    .SLOTS     (SLOTS),
    .ROW_BYTES (ROW_BYTES)
  ) u_pop (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (pop_start),
    .start_byte         (cfg_r.start_byte),
    .q_empty            (q_empty),
    .busy               (pop_busy),
    .retire             (retire),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_command        (out_command),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last),
    .out_checksum_ok    (out_checksum_ok)
  );

  // A result word only appears while a pop holds the input side off.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("result word presented while input side is open");

  // An accepted pop closes the input side in the next cycle.
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == spd_pkg::MODE_POP)) |=> !in_ready)
    else $error("pop accepted but sequencer did not start");

  // An empty-queue word is always the only word of its pop.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == spd_pkg::KIND_EMPTY)) |-> out_last)
    else $error("empty-queue word without last");

  // Row writes only happen for a byte accepted in that cycle.
  a_write_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (in_valid && in_ready && (in_mode == spd_pkg::MODE_BYTE)))
    else $error("row write without an accepted byte");

endmodule

FILE: design/spd_ram.sv
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/spd_rx.sv
// ---------------------------------------------------------------------------
// Frame receiver
// Tracks frame state, timeout and the head side of the packet ring, and
// writes received bytes into the head row.
// ---------------------------------------------------------------------------
module spd_rx #(
  parameter int SLOTS     = 8,
  parameter int ROW_BYTES = 32
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  spd_pkg::cfg_t                                  cfg,
  input  spd_pkg::rx_cmd_t                               cmd,
  input  logic                                           retire,
  output logic                                           q_empty,
  output logic                                           wr_en,
  output logic [$clog2(SLOTS)+$clog2(ROW_BYTES)-1:0]     wr_addr,
  output logic [7:0]                                     wr_data
);

  localparam int SW  = $clog2(SLOTS);
  localparam int IW  = $clog2(ROW_BYTES);
  localparam int FW  = $clog2(ROW_BYTES + 1);
  localparam int HW  = $clog2(SLOTS + 1);

  logic [SW-1:0] head_r, head_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [FW-1:0] fbc_r, fbc_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    tick_r, tick_nxt;
  logic          tout_r, tout_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [IW-1:0] wr_idx;
  logic          full;

  assign full    = (held_r == HW'(SLOTS));
  assign q_empty = (held_r == '0);
  assign wr_addr = {head_r, wr_idx};
  assign wr_data = cmd.data;

  // Frame state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      held_r     <= '0;
      in_frame_r <= 1'b0;
      fbc_r      <= '0;
      prev_r     <= '0;
      tick_r     <= '0;
      tout_r     <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      held_r     <= held_nxt;
      in_frame_r <= in_frame_nxt;
      fbc_r      <= fbc_nxt;
      prev_r     <= prev_nxt;
      tick_r     <= tick_nxt;
      tout_r     <= tout_nxt;
    end
  end

  // The length byte is kept aside so the end-of-frame check needs no read.
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  // Byte, tick and retire handling.
  always_comb begin
    head_nxt     = head_r;
    held_nxt     = held_r;
    in_frame_nxt = in_frame_r;
    fbc_nxt      = fbc_r;
    prev_nxt     = prev_r;
    tick_nxt     = tick_r;
    tout_nxt     = tout_r;
    len_nxt      = len_r;
    wr_en        = 1'b0;
    wr_idx       = fbc_r[IW-1:0];

    if (retire) begin
      held_nxt = held_r - HW'(1);
    end

    if (cmd.tick_stb) begin
      if (tick_r > cfg.timeout_limit) begin
        tout_nxt = 1'b1;
      end else if (tick_r != spd_pkg::TICK_MAX) begin
        tick_nxt = tick_r + 8'd1;
      end
    end

    if (cmd.byte_stb) begin
      prev_nxt = cmd.data;
      if (!in_frame_r) begin
        // Idle: hunt for the start byte while the ring has room.
        fbc_nxt = '0;
        if ((cmd.data == cfg.start_byte) && !full) begin
          wr_en        = 1'b1;
          wr_idx       = '0;
          fbc_nxt      = FW'(1);
          in_frame_nxt = 1'b1;
          tick_nxt     = '0;
          tout_nxt     = 1'b0;
        end
      end else if (fbc_r >= FW'(ROW_BYTES)) begin
        // The row is full: drop the frame.
        in_frame_nxt = 1'b0;
        fbc_nxt      = '0;
      end else begin
        wr_en = 1'b1;
        if (8'(fbc_r) == spd_pkg::LEN_POS) begin
          len_nxt = cmd.data;
        end
        if ((cmd.data == cfg.end_byte_two) && (prev_r == cfg.end_byte_one)) begin
          // End pair seen: commit when the length byte agrees with the count.
          if ((8'(fbc_r) >= spd_pkg::HDR_BYTES) &&
              (len_r == (8'(fbc_r) - spd_pkg::HDR_BYTES))) begin
            head_nxt = (head_r == SW'(SLOTS - 1)) ? '0 : head_r + SW'(1);
            held_nxt = held_r + HW'(1);
          end
          in_frame_nxt = 1'b0;
          fbc_nxt      = '0;
        end else begin
          fbc_nxt = fbc_r + FW'(1);
        end
        if (tout_r) begin
          in_frame_nxt = 1'b0;
          fbc_nxt      = '0;
        end
      end
    end
  end

endmodule

FILE: design/spd_pop.sv
// ---------------------------------------------------------------------------
// Pop sequencer
// Walks the oldest packet row through one shared 16-bit adder to check the
// sum, then reads the payload again and hands it out word by word.
// ---------------------------------------------------------------------------
module spd_pop #(
  parameter int SLOTS     = 8,
  parameter int ROW_BYTES = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [7:0]                                 start_byte,
  input  logic                                       q_empty,
  output logic                                       busy,
  output logic                                       retire,
  output logic [$clog2(SLOTS)+$clog2(ROW_BYTES)-1:0] rd_addr,
  input  logic [7:0]                                 rd_data,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [1:0]                                 out_kind,
  output logic [7:0]                                 out_command,
  output logic [4:0]                                 out_payload_length,
  output logic [7:0]                                 out_payload_byte,
  output logic [4:0]                                 out_byte_index,
  output logic                                       out_last,
  output logic                                       out_checksum_ok
);

  localparam int SW = $clog2(SLOTS);
  localparam int IW = $clog2(ROW_BYTES);

  spd_pkg::pop_state_t state_r, state_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    lo_r, lo_nxt;
  spd_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [4:0]    bidx_r, bidx_nxt;
  logic          last_r, last_nxt;
  logic          ok_r, ok_nxt;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] data_idx;
  logic [7:0]    data_pos;
  logic [8:0]    pay_end;
  logic [15:0]   sum_add;

  // The shared adder.
  assign sum_add  = sum_r + 16'(rd_data);
  // Row position whose read data arrives in this cycle of the sum pass.
  assign data_idx = idx_r - IW'(1);
  assign data_pos = 8'(data_idx);
  assign pay_end  = 9'(len_r) + 9'(spd_pkg::PAY_POS);
  assign rd_addr  = {tail_r, rd_idx};

  assign busy               = (state_r != spd_pkg::P_IDLE);
  assign out_valid          = (state_r == spd_pkg::P_OUT);
  assign out_kind           = kind_r;
  assign out_command        = cmd_r;
  assign out_payload_length = len_r[4:0];
  assign out_payload_byte   = byte_r;
  assign out_byte_index     = bidx_r;
  assign out_last           = last_r;
  assign out_checksum_ok    = ok_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spd_pkg::P_IDLE;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
    end
  end

  // Working and output registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    lo_r   <= lo_nxt;
    kind_r <= kind_nxt;
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    byte_r <= byte_nxt;
    bidx_r <= bidx_nxt;
    last_r <= last_nxt;
    ok_r   <= ok_nxt;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    tail_nxt  = tail_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    kind_nxt  = kind_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    byte_nxt  = byte_r;
    bidx_nxt  = bidx_r;
    last_nxt  = last_r;
    ok_nxt    = ok_r;
    retire    = 1'b0;
    rd_idx    = idx_r;

    case (state_r)
      spd_pkg::P_IDLE: begin
        if (start) begin
          if (q_empty) begin
            kind_nxt  = spd_pkg::KIND_EMPTY;
            cmd_nxt   = '0;
            len_nxt   = '0;
            byte_nxt  = '0;
            bidx_nxt  = '0;
            last_nxt  = 1'b1;
            ok_nxt    = 1'b0;
            state_nxt = spd_pkg::P_OUT;
          end else begin
            sum_nxt   = 16'(start_byte);
            idx_nxt   = IW'(1);
            state_nxt = spd_pkg::P_SUM;
          end
        end
      end

      // Sum pass: one read issued and one byte taken in each cycle.
      spd_pkg::P_SUM: begin
        idx_nxt = idx_r + IW'(1);
        if (data_pos == spd_pkg::CMD_POS) begin
          cmd_nxt = rd_data;
          sum_nxt = sum_add;
        end else if (data_pos == spd_pkg::LEN_POS) begin
          len_nxt = rd_data;
          sum_nxt = sum_add;
        end else if (data_pos >= spd_pkg::PAY_POS) begin
          if (9'(data_pos) < pay_end) begin
            sum_nxt = sum_add;
          end else if (9'(data_pos) == pay_end) begin
            lo_nxt = rd_data;
          end else begin
            // High checksum byte: the verdict is settled.
            ok_nxt = (sum_r == {rd_data, lo_r});
            if (len_r == '0) begin
              kind_nxt  = spd_pkg::KIND_NOPAY;
              byte_nxt  = '0;
              bidx_nxt  = '0;
              last_nxt  = 1'b1;
              state_nxt = spd_pkg::P_OUT;
            end else begin
              cnt_nxt   = '0;
              state_nxt = spd_pkg::P_RD;
            end
          end
        end
      end

      // Payload pass: fetch one byte.
      spd_pkg::P_RD: begin
        rd_idx    = IW'(cnt_r + spd_pkg::PAY_POS);
        state_nxt = spd_pkg::P_LD;
      end

      spd_pkg::P_LD: begin
        kind_nxt  = spd_pkg::KIND_PAYLOAD;
        byte_nxt  = rd_data;
        bidx_nxt  = cnt_r[4:0];
        last_nxt  = ((cnt_r + 8'd1) == len_r);
        state_nxt = spd_pkg::P_OUT;
      end

      // Hold the word until it is taken.
      spd_pkg::P_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = spd_pkg::P_IDLE;
            if (kind_r != spd_pkg::KIND_EMPTY) begin
              retire   = 1'b1;
              tail_nxt = (tail_r == SW'(SLOTS - 1)) ? '0 : tail_r + SW'(1);
            end
          end else begin
            cnt_nxt   = cnt_r + 8'd1;
            state_nxt = spd_pkg::P_RD;
          end
        end
      end

      default: begin
        state_nxt = spd_pkg::P_IDLE;
      end
    endcase
  end

endmodule
